// ===== rtl/aqif_pkg.sv =====
`default_nettype none

package aqif_pkg;

    // Field widths fixed by the stream format.
    localparam int unsigned PmW   = 16;
    localparam int unsigned AqiW  = 17;
    localparam int unsigned GasW  = 9;

    // Datapath widths. Concentrations reach 655350 tenths, the scaled numerator stays
    // below 2^27, and the reciprocal of each doubled band width is taken at 2^27.
    localparam int unsigned CW         = 20;
    localparam int unsigned NW         = 27;
    localparam int unsigned RW         = 21;
    localparam int unsigned PW         = NW + RW;
    localparam int unsigned QW         = 16;
    localparam int unsigned DW         = 12;
    localparam int unsigned TW         = QW + DW;
    localparam int unsigned RecipShift = 27;

    localparam logic [AqiW-1:0] AqiNone = '1;
    localparam logic [GasW-1:0] GasNone = '1;

    // Upper band edges of PM2.5 in whole ug/m3 (12.0, 35.4, 55.4, 150.4, 250.4, 350.4).
    localparam logic [PmW-1:0] FineTop0 = 16'd12;
    localparam logic [PmW-1:0] FineTop1 = 16'd35;
    localparam logic [PmW-1:0] FineTop2 = 16'd55;
    localparam logic [PmW-1:0] FineTop3 = 16'd150;
    localparam logic [PmW-1:0] FineTop4 = 16'd250;
    localparam logic [PmW-1:0] FineTop5 = 16'd350;

    // Upper band edges of PM10 in whole ug/m3.
    localparam logic [PmW-1:0] CoarseTop0 = 16'd54;
    localparam logic [PmW-1:0] CoarseTop1 = 16'd154;
    localparam logic [PmW-1:0] CoarseTop2 = 16'd254;
    localparam logic [PmW-1:0] CoarseTop3 = 16'd354;
    localparam logic [PmW-1:0] CoarseTop4 = 16'd424;
    localparam logic [PmW-1:0] CoarseTop5 = 16'd504;

    // VOC step edges and values.
    localparam logic signed [PmW-1:0] VocEdge1 = 16'sd100;
    localparam logic signed [PmW-1:0] VocEdge2 = 16'sd200;
    localparam logic signed [PmW-1:0] VocEdge3 = 16'sd300;
    localparam logic signed [PmW-1:0] VocEdge4 = 16'sd400;
    localparam logic [GasW-1:0] GasStep0 = 9'd25;
    localparam logic [GasW-1:0] GasStep1 = 9'd75;
    localparam logic [GasW-1:0] GasStep2 = 9'd125;
    localparam logic [GasW-1:0] GasStep3 = 9'd175;
    localparam logic [GasW-1:0] GasStep4 = 9'd250;

    typedef enum logic [3:0] {
        BAND_F0 = 4'd0,
        BAND_F1 = 4'd1,
        BAND_F2 = 4'd2,
        BAND_F3 = 4'd3,
        BAND_F4 = 4'd4,
        BAND_F5 = 4'd5,
        BAND_F6 = 4'd6,
        BAND_C0 = 4'd7,
        BAND_C1 = 4'd8,
        BAND_C2 = 4'd9,
        BAND_C3 = 4'd10,
        BAND_C4 = 4'd11,
        BAND_C5 = 4'd12,
        BAND_C6 = 4'd13
    } t_band_code;

    // cl: low concentration edge, m: index span, d: concentration span,
    // r: floor(2^27 / (2*d)), il: low index edge.
    typedef struct packed {
        logic [11:0] cl;
        logic [6:0]  m;
        logic [10:0] d;
        logic [RW-1:0] r;
        logic [8:0]  il;
    } t_band;

    // Items that ride alongside the interpolation units.
    typedef struct packed {
        logic            pv;
        logic            sp;
        logic [GasW-1:0] gas;
        logic [PmW-1:0]  chosen;
    } t_side;

    // Load enables of the interpolation stages two to five.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_ctl;

    function automatic t_band band_lookup(input t_band_code code);
        t_band b;
        unique case (code)
            BAND_F0: b = '{12'd0,    7'd50, 11'd120,  21'd559240,  9'd0};
            BAND_F1: b = '{12'd121,  7'd49, 11'd233,  21'd288020,  9'd51};
            BAND_F2: b = '{12'd355,  7'd49, 11'd199,  21'd337230,  9'd101};
            BAND_F3: b = '{12'd555,  7'd49, 11'd949,  21'd70715,   9'd151};
            BAND_F4: b = '{12'd1505, 7'd99, 11'd999,  21'd67176,   9'd201};
            BAND_F5: b = '{12'd2505, 7'd99, 11'd999,  21'd67176,   9'd301};
            BAND_F6: b = '{12'd3505, 7'd99, 11'd1499, 21'd44769,   9'd401};
            BAND_C0: b = '{12'd0,    7'd50, 11'd54,   21'd1242756, 9'd0};
            BAND_C1: b = '{12'd55,   7'd49, 11'd99,   21'd677867,  9'd51};
            BAND_C2: b = '{12'd155,  7'd49, 11'd99,   21'd677867,  9'd101};
            BAND_C3: b = '{12'd255,  7'd49, 11'd99,   21'd677867,  9'd151};
            BAND_C4: b = '{12'd355,  7'd99, 11'd69,   21'd972592,  9'd201};
            BAND_C5: b = '{12'd425,  7'd99, 11'd79,   21'd849479,  9'd301};
            BAND_C6: b = '{12'd505,  7'd99, 11'd99,   21'd677867,  9'd401};
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/aqif_front.sv =====
`default_nettype none

// First stage: scales PM2.5 to tenths, picks the band of every reading,
// maps the VOC index to its step and chooses the particle reading to pass on.
module aqif_front
    import aqif_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [PmW-1:0]         i_pm25_primary,
    input  wire logic [PmW-1:0]         i_pm10_primary,
    input  wire logic                   i_primary_valid,
    input  wire logic [PmW-1:0]         i_pm25_secondary,
    input  wire logic                   i_secondary_present,
    input  wire logic signed [PmW-1:0]  i_voc_index,
    input  wire logic                   i_voc_valid,
    output logic [CW-1:0]               o_c_first,
    output t_band_code                  o_code_first,
    output logic [CW-1:0]               o_c_second,
    output t_band_code                  o_code_second,
    output logic [CW-1:0]               o_c_coarse,
    output t_band_code                  o_code_coarse,
    output t_side                       o_side
);

    function automatic t_band_code fine_code(input logic [PmW-1:0] p);
        t_band_code c;
        if (p <= FineTop0) begin
            c = BAND_F0;
        end else if (p <= FineTop1) begin
            c = BAND_F1;
        end else if (p <= FineTop2) begin
            c = BAND_F2;
        end else if (p <= FineTop3) begin
            c = BAND_F3;
        end else if (p <= FineTop4) begin
            c = BAND_F4;
        end else if (p <= FineTop5) begin
            c = BAND_F5;
        end else begin
            c = BAND_F6;
        end
        return c;
    endfunction

    function automatic t_band_code coarse_code(input logic [PmW-1:0] p);
        t_band_code c;
        if (p <= CoarseTop0) begin
            c = BAND_C0;
        end else if (p <= CoarseTop1) begin
            c = BAND_C1;
        end else if (p <= CoarseTop2) begin
            c = BAND_C2;
        end else if (p <= CoarseTop3) begin
            c = BAND_C3;
        end else if (p <= CoarseTop4) begin
            c = BAND_C4;
        end else if (p <= CoarseTop5) begin
            c = BAND_C5;
        end else begin
            c = BAND_C6;
        end
        return c;
    endfunction

    function automatic logic [CW-1:0] times_ten(input logic [PmW-1:0] p);
        return ({1'b0, p, 3'b000} + {3'b000, p, 1'b0});
    endfunction

    t_side n_side;

    always_comb begin
        n_side.pv = i_primary_valid;
        n_side.sp = i_secondary_present;
        if (!i_voc_valid) begin
            n_side.gas = GasNone;
        end else if (i_voc_index < VocEdge1) begin
            n_side.gas = GasStep0;
        end else if (i_voc_index < VocEdge2) begin
            n_side.gas = GasStep1;
        end else if (i_voc_index < VocEdge3) begin
            n_side.gas = GasStep2;
        end else if (i_voc_index < VocEdge4) begin
            n_side.gas = GasStep3;
        end else begin
            n_side.gas = GasStep4;
        end
        if (i_primary_valid) begin
            n_side.chosen = i_pm25_primary;
        end else if (i_secondary_present) begin
            n_side.chosen = i_pm25_secondary;
        end else begin
            n_side.chosen = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_c_first     <= times_ten(i_pm25_primary);
            o_code_first  <= fine_code(i_pm25_primary);
            o_c_second    <= times_ten(i_pm25_secondary);
            o_code_second <= fine_code(i_pm25_secondary);
            o_c_coarse    <= {{(CW-PmW){1'b0}}, i_pm10_primary};
            o_code_coarse <= coarse_code(i_pm10_primary);
            o_side        <= n_side;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aqif_interp.sv =====
`default_nettype none

// Four-stage band interpolation with exact half-up rounding. The quotient
// by the doubled band width is taken through a reciprocal product, then
// corrected by at most one against the remainder.
module aqif_interp
    import aqif_pkg::*;
(
    input  wire logic          i_clk,
    input  wire t_stage_ctl    i_ctl,
    input  wire t_band_code    i_code,
    input  wire logic [CW-1:0] i_c,
    output logic [QW-1:0]      o_aqi
);

    t_band          b2, b3, b4, b5;
    logic [CW-1:0]  off2;
    logic [NW-1:0]  n_num;
    logic [PW-1:0]  prod3;
    logic [DW-1:0]  dd4, dd5;
    logic [NW-1:0]  rem5;
    logic [QW:0]    q5;

    t_band_code     r2_code, r3_code, r4_code;
    logic [NW-1:0]  r2_num, r3_num, r4_num;
    logic [QW-1:0]  r3_q0, r4_q0;
    logic [TW-1:0]  r4_t;

    always_comb begin
        b2    = band_lookup(i_code);
        off2  = i_c - CW'(b2.cl);
        n_num = NW'((NW'(b2.m) * NW'(off2)) << 1) + NW'(b2.d);

        b3    = band_lookup(r2_code);
        prod3 = PW'(r2_num) * PW'(b3.r);

        b4    = band_lookup(r3_code);
        dd4   = {b4.d, 1'b0};

        b5    = band_lookup(r4_code);
        dd5   = {b5.d, 1'b0};
        rem5  = r4_num - NW'(r4_t);
        q5    = {1'b0, r4_q0} + (QW+1)'(rem5 >= NW'(dd5)) + (QW+1)'(b5.il);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2) begin
            r2_code <= i_code;
            r2_num  <= n_num;
        end
        if (i_ctl.s3) begin
            r3_code <= r2_code;
            r3_num  <= r2_num;
            r3_q0   <= prod3[RecipShift +: QW];
        end
        if (i_ctl.s4) begin
            r4_code <= r3_code;
            r4_num  <= r3_num;
            r4_q0   <= r3_q0;
            r4_t    <= TW'(r3_q0) * TW'(dd4);
        end
        if (i_ctl.s5) begin
            o_aqi <= q5[QW-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/air_quality_index_fusion_top.sv =====
`default_nettype none

// Channel   Dir  Signals                      Payload
// --------  ---  ---------------------------  -----------------------------------------
// s (in)    in   i_s_tvalid/o_s_tready        tdata: pm25_primary, pm10_primary,
//                i_s_tdata[63:0], tuser[2:0]   pm25_secondary, voc_index; tuser: flags
// m (out)   out  o_m_tvalid/i_m_tready        tdata: four sub-indices, final AQI,
//                o_m_tdata[95:0]               chosen particle reading
//
// A request passes to the output register through six stages: band pick, numerator,
// reciprocal product, quotient check product, correction and the priority select.
// One request can enter in every cycle while the output is not stalled.
// Reset (i_rst_n low at a clock edge) empties every stage; data registers keep content.
// A stalled output holds its request; stages behind it keep filling bubbles, so new
// requests are taken until every stage holds one.
module air_quality_index_fusion_top
    import aqif_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [15:0] pm25_primary, [31:16] pm10_primary, [47:32] pm25_secondary,
    // [63:48] voc_index (signed)
    input  wire logic [63:0] i_s_tdata,
    // [0] primary_valid, [1] secondary_present, [2] voc_valid
    input  wire logic [2:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [16:0] aqi_pm25_first, [33:17] aqi_pm25_second, [50:34] aqi_coarse,
    // [59:51] aqi_gas, [76:60] aqi_final, [92:77] pm_chosen, [95:93] zero
    output logic [95:0]      o_m_tdata
);

    localparam int unsigned Stages = 6;

    // One valid bit per stage; stage 0 is the band pick, the last one is the
    // output register.
    logic [Stages-1:0] r_valid;
    logic [Stages-1:0] stage_en;
    t_stage_ctl        ctl;

    logic [CW-1:0]     c_first, c_second, c_coarse;
    t_band_code        code_first, code_second, code_coarse;
    t_side             side_front;
    t_side             r_side [1:4];
    logic [QW-1:0]     aqi_first, aqi_second, aqi_coarse;

    logic [AqiW-1:0]   n_first, n_second, n_coarse, n_final;
    logic [AqiW-1:0]   r_first, r_second, r_coarse, r_final;
    logic [GasW-1:0]   r_gas;
    logic [PmW-1:0]    r_chosen;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        stage_en[Stages-1] = !r_valid[Stages-1] || i_m_tready;
        for (int i = Stages - 2; i >= 0; i--) begin
            stage_en[i] = !r_valid[i] || stage_en[i+1];
        end
        ctl.s2 = stage_en[1];
        ctl.s3 = stage_en[2];
        ctl.s4 = stage_en[3];
        ctl.s5 = stage_en[4];
    end

    assign o_s_tready = stage_en[0];
    assign o_m_tvalid = r_valid[Stages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_en[0]) begin
                r_valid[0] <= i_s_tvalid;
            end
            for (int i = 1; i < Stages; i++) begin
                if (stage_en[i]) begin
                    r_valid[i] <= r_valid[i-1];
                end
            end
        end
    end

    aqif_front u_front (
        .i_clk               (i_clk),
        .i_en                (stage_en[0]),
        .i_pm25_primary      (i_s_tdata[15:0]),
        .i_pm10_primary      (i_s_tdata[31:16]),
        .i_primary_valid     (i_s_tuser[0]),
        .i_pm25_secondary    (i_s_tdata[47:32]),
        .i_secondary_present (i_s_tuser[1]),
        .i_voc_index         (i_s_tdata[63:48]),
        .i_voc_valid         (i_s_tuser[2]),
        .o_c_first           (c_first),
        .o_code_first        (code_first),
        .o_c_second          (c_second),
        .o_code_second       (code_second),
        .o_c_coarse          (c_coarse),
        .o_code_coarse       (code_coarse),
        .o_side              (side_front)
    );

    aqif_interp u_interp_first (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_code (code_first),
        .i_c    (c_first),
        .o_aqi  (aqi_first)
    );

    aqif_interp u_interp_second (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_code (code_second),
        .i_c    (c_second),
        .o_aqi  (aqi_second)
    );

    aqif_interp u_interp_coarse (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_code (code_coarse),
        .i_c    (c_coarse),
        .o_aqi  (aqi_coarse)
    );

    // Flags, the VOC step and the chosen reading travel beside the interpolators.
    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_side[1] <= side_front;
        end
        for (int i = 2; i <= 4; i++) begin
            if (stage_en[i]) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Missing readings become -1; the final index takes the first valid one in the
    // order primary PM2.5, secondary PM2.5, PM10, VOC.
    always_comb begin
        n_first  = r_side[4].pv ? {1'b0, aqi_first}  : AqiNone;
        n_second = r_side[4].sp ? {1'b0, aqi_second} : AqiNone;
        n_coarse = r_side[4].pv ? {1'b0, aqi_coarse} : AqiNone;
        if (r_side[4].pv) begin
            n_final = n_first;
        end else if (r_side[4].sp) begin
            n_final = n_second;
        end else if (r_side[4].pv) begin
            n_final = n_coarse;
        end else begin
            n_final = {{(AqiW-GasW){r_side[4].gas[GasW-1]}}, r_side[4].gas};
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[Stages-1]) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_coarse <= n_coarse;
            r_final  <= n_final;
            r_gas    <= r_side[4].gas;
            r_chosen <= r_side[4].chosen;
        end
    end

    assign o_m_tdata = {3'b000, r_chosen, r_final, r_gas, r_coarse, r_second, r_first};

    // An accepted request always lands in the first stage.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_valid[0])
        else $error("accepted request did not enter the first stage");

    // With every stage full and the output stalled, no request may be taken.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_valid) && !i_m_tready) |-> !o_s_tready)
        else $error("request taken while the pipeline was full");

    // A final index of -1 means no particle sub-index was valid.
    a_final_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_final == AqiNone)) |->
            ((r_first == AqiNone) && (r_second == AqiNone) && (r_coarse == AqiNone)))
        else $error("final index missing although a sub-index was valid");

    // Both primary sub-indices share the primary validity flag.
    a_primary_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((r_first == AqiNone) == (r_coarse == AqiNone)))
        else $error("primary PM2.5 and PM10 sub-indices disagree on validity");

endmodule

`default_nettype wire

// ===== test/tb_air_quality_index_fusion_top.sv =====
`timescale 1ns / 1ps

module tb_air_quality_index_fusion_top;
    import aqif_pkg::*;

    // One set of sensor readings, as it travels on the slave side of the block.
    typedef struct {
        logic [PmW-1:0]        p25a;
        logic [PmW-1:0]        p10;
        logic [PmW-1:0]        p25b;
        logic signed [PmW-1:0] voc;
        logic                  pv;
        logic                  sp;
        logic                  vv;
    } reading_t;

    // One result, unpacked from the master side data word.
    typedef struct {
        logic signed [AqiW-1:0] first;
        logic signed [AqiW-1:0] second;
        logic signed [AqiW-1:0] coarse;
        logic signed [GasW-1:0] gas;
        logic signed [AqiW-1:0] fin;
        logic [PmW-1:0]         chosen;
    } aqi_result_t;

    // Linear interpolation within one band, rounded half up in exact integers.
    function automatic int band_interp(int cl, int ch, int il, int ih, longint c);
        longint d;
        longint off;
        d = ch - cl;
        off = (c >= cl) ? c - cl : 0;
        return il + int'((2 * (ih - il) * off + d) / (2 * d));
    endfunction

    // PM2.5 sub-index; the concentration is given in tenths of ug/m3. Readings past
    // the top band extrapolate along that band's line.
    function automatic int fine_aqi(longint c);
        if (c <= 120) return band_interp(0, 120, 0, 50, c);
        if (c <= 354) return band_interp(121, 354, 51, 100, c);
        if (c <= 554) return band_interp(355, 554, 101, 150, c);
        if (c <= 1504) return band_interp(555, 1504, 151, 200, c);
        if (c <= 2504) return band_interp(1505, 2504, 201, 300, c);
        if (c <= 3504) return band_interp(2505, 3504, 301, 400, c);
        return band_interp(3505, 5004, 401, 500, c);
    endfunction

    // PM10 sub-index in whole ug/m3, with the two upper bands split as EPA gives them.
    function automatic int coarse_aqi(longint c);
        if (c <= 54) return band_interp(0, 54, 0, 50, c);
        if (c <= 154) return band_interp(55, 154, 51, 100, c);
        if (c <= 254) return band_interp(155, 254, 101, 150, c);
        if (c <= 354) return band_interp(255, 354, 151, 200, c);
        if (c <= 424) return band_interp(355, 424, 201, 300, c);
        if (c <= 504) return band_interp(425, 504, 301, 400, c);
        return band_interp(505, 604, 401, 500, c);
    endfunction

    // Holds the results still owed by the block and compares each one as it leaves.
    class aqi_scoreboard;
        aqi_result_t pending_aqi[$];
        int          fault_count;
        int          checked_count;

        function aqi_result_t aqi_predict(reading_t r);
            aqi_result_t e;
            int          a1;
            int          a2;
            int          a3;
            int          a4;
            int          v;
            v  = int'(r.voc);
            a1 = r.pv ? fine_aqi(longint'(r.p25a) * 10) : -1;
            a2 = r.sp ? fine_aqi(longint'(r.p25b) * 10) : -1;
            a3 = r.pv ? coarse_aqi(longint'(r.p10)) : -1;
            a4 = -1;
            if (r.vv) begin
                // A negative index lands in the lowest step.
                if (v < 100) a4 = 25;
                else if (v < 200) a4 = 75;
                else if (v < 300) a4 = 125;
                else if (v < 400) a4 = 175;
                else a4 = 250;
            end
            e.first  = a1;
            e.second = a2;
            e.coarse = a3;
            e.gas    = a4;
            if (a1 >= 0) e.fin = a1;
            else if (a2 >= 0) e.fin = a2;
            else if (a3 >= 0) e.fin = a3;
            else e.fin = a4;
            // With neither PM2.5 sensor present, the chosen reading is zero.
            e.chosen = r.pv ? r.p25a : (r.sp ? r.p25b : '0);
            return e;
        endfunction

        function void note(logic [63:0] tdata, logic [2:0] tuser);
            reading_t r;
            r.p25a = tdata[15:0];
            r.p10  = tdata[31:16];
            r.p25b = tdata[47:32];
            r.voc  = tdata[63:48];
            r.pv   = tuser[0];
            r.sp   = tuser[1];
            r.vv   = tuser[2];
            pending_aqi.push_back(aqi_predict(r));
        endfunction

        function void compare_field(string label, longint want, longint got);
            if (want != got) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("[%0t] mismatch on %s: expected %0d, got %0d",
                             $realtime, label, want, got);
            end
        endfunction

        function void check(logic [95:0] tdata);
            aqi_result_t e;
            checked_count++;
            if (pending_aqi.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("[%0t] result with no request waiting: %h", $realtime, tdata);
                return;
            end
            e = pending_aqi.pop_front();
            compare_field("aqi_pm25_first", e.first, $signed(tdata[16:0]));
            compare_field("aqi_pm25_second", e.second, $signed(tdata[33:17]));
            compare_field("aqi_coarse", e.coarse, $signed(tdata[50:34]));
            compare_field("aqi_gas", e.gas, $signed(tdata[59:51]));
            compare_field("aqi_final", e.fin, $signed(tdata[76:60]));
            compare_field("pm_chosen", e.chosen, tdata[92:77]);
            compare_field("pad bits", 0, tdata[95:93]);
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [63:0] i_s_tdata  = '0;
    logic [2:0]  i_s_tuser  = '0;
    logic        i_m_tready = 1'b1;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [95:0] o_m_tdata;

    // While this is set, both the sender and the receiver insert random idle bursts.
    bit idle_on = 1'b1;
    int sent_count;

    aqi_scoreboard sb = new;

    air_quality_index_fusion_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The monitor samples both handshakes at the clock edge. All inputs change through
    // nonblocking assignments, so it sees the values that the block saw at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note(i_s_tdata, i_s_tuser);
            if (o_m_tvalid && i_m_tready) sb.check(o_m_tdata);
        end
    end

    // The receiver drops ready in random bursts while idling is on.
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end
        end
    end

    function automatic reading_t make_reading(int p25a, int p10, int p25b, int voc,
                                              bit pv, bit sp, bit vv);
        reading_t r;
        r.p25a = p25a;
        r.p10  = p10;
        r.p25b = p25b;
        r.voc  = voc;
        r.pv   = pv;
        r.sp   = sp;
        r.vv   = vv;
        return r;
    endfunction

    // Random readings: most sit within or just past the table bands, where the
    // interpolation and the band choice matter; some use the whole 16-bit range.
    function automatic reading_t random_reading();
        reading_t r;
        int       sel;
        sel = $urandom_range(0, 9);
        r.p25a = (sel < 6) ? $urandom_range(0, 520) :
                 (sel < 8) ? $urandom_range(0, 2000) : $urandom;
        sel = $urandom_range(0, 9);
        r.p10  = (sel < 6) ? $urandom_range(0, 700) :
                 (sel < 8) ? $urandom_range(0, 3000) : $urandom;
        sel = $urandom_range(0, 9);
        r.p25b = (sel < 6) ? $urandom_range(0, 520) :
                 (sel < 8) ? $urandom_range(0, 2000) : $urandom;
        sel = $urandom_range(0, 9);
        r.voc  = (sel < 7) ? int'($urandom_range(0, 550)) - 50 : $urandom;
        r.pv   = $urandom_range(0, 3) != 0;
        r.sp   = $urandom_range(0, 3) != 0;
        r.vv   = $urandom_range(0, 3) != 0;
        return r;
    endfunction

    // Presents one request and holds it until the block takes it. Valid stays high
    // into the next request unless the sender decides to idle.
    task automatic send_reading(input reading_t r);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {r.voc, r.p25b, r.p10, r.p25a};
        i_s_tuser  <= {r.vv, r.sp, r.pv};
        do @(posedge i_clk); while (!o_s_tready);
        sent_count++;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_aqi.size() != 0);
    endtask

    // Band edges on both sides of every breakpoint, for both particle tables, and
    // the VOC step edges, the negative index among them.
    task automatic run_directed();
        int fine_edge[14]   = '{12, 13, 35, 36, 55, 56, 150, 151, 250, 251,
                                350, 351, 500, 501};
        int coarse_edge[14] = '{54, 55, 154, 155, 254, 255, 354, 355, 424, 425,
                                504, 505, 604, 605};
        int voc_edge[14]    = '{-32768, -1, 0, 99, 100, 199, 200, 299, 300, 399,
                                400, 401, 32767, 250};
        int k;
        send_reading(make_reading(0, 0, 0, 0, 1, 1, 1));
        send_reading(make_reading(65535, 65535, 65535, 32767, 1, 1, 1));
        for (k = 0; k < 14; k++)
            send_reading(make_reading(fine_edge[k], coarse_edge[k], fine_edge[13 - k],
                                      voc_edge[k], 1, 1, 1));
        // Every combination of the three flags decides which sub-index wins and
        // which reading is passed on, including the case with nothing valid.
        for (k = 0; k < 8; k++)
            send_reading(make_reading($urandom_range(0, 600), $urandom_range(0, 700),
                                      $urandom_range(0, 600), $urandom_range(0, 500),
                                      k[0], k[1], k[2]));
    endtask

    initial begin
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // Random phase with idling on both sides. Halfway, the sender holds off
        // until the block has returned every request it took.
        for (n = 0; n < 1400; n++) begin
            if (n == 700) drain_results();
            send_reading(random_reading());
        end

        // Last phase runs at full rate with the receiver always ready.
        idle_on = 1'b0;
        for (n = 0; n < 350; n++)
            send_reading(random_reading());

        drain_results();
        repeat (12) @(posedge i_clk);

        if (sb.pending_aqi.size() != 0) begin
            sb.fault_count++;
            $display("%0d expected results never arrived", sb.pending_aqi.size());
        end
        $display("Covered %0d reading sets: band edges, all flag combinations and random",
                 sent_count);
        $display("readings under idling, a full drain and back-to-back traffic; %0d results.",
                 sb.checked_count);
        if (sb.fault_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches in total", sb.fault_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2000000;
        $display("Timeout waiting for the block");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
